FILE: src/swt_pkg.sv
// Shared types and constants for the shell word tokenizer.
// No dependencies; used by every module of the block.
package swt_pkg;

   localparam int POS_BITS = 16;
   localparam int BYTE_BITS = 8;
   localparam int OUT_POS_BITS = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int RSP_TDATA_BITS = 48;

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   localparam logic [BYTE_BITS-1:0] CH_NUL = 8'h00;
   localparam logic [BYTE_BITS-1:0] CH_SQ  = 8'h27;
   localparam logic [BYTE_BITS-1:0] CH_DQ  = 8'h22;
   localparam logic [BYTE_BITS-1:0] CH_BS  = 8'h5C;
   localparam logic [BYTE_BITS-1:0] CH_NL  = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CH_SP  = 8'h20;
   localparam logic [BYTE_BITS-1:0] CH_TAB = 8'h09;
   localparam logic [BYTE_BITS-1:0] CH_CR  = 8'h0D;

   // register index of the line separator
   localparam logic CSR_IDX_SEPARATOR = 1'b0;

   typedef enum logic [2:0] {
      MODE_UNQ  = 3'd0,
      MODE_BS   = 3'd1,
      MODE_SQ   = 3'd2,
      MODE_DQ   = 3'd3,
      MODE_DQBS = 3'd4
   } mode_type;

   typedef struct packed {
      logic                    append_valid;
      logic [BYTE_BITS-1:0]    append_byte;
      logic                    word_done;
      logic [OUT_POS_BITS-1:0] word_start;
      logic [OUT_POS_BITS-1:0] word_end;
      logic                    line_break;
      logic                    string_done;
      logic [2:0]              missing_quote;
   } rsp_type;

   typedef struct packed {
      logic out_valid;
      logic skid_valid;
   } buf_status_type;

   function automatic logic is_space(input logic [BYTE_BITS-1:0] c);
      is_space = (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

FILE: src/swt_core.sv
// Tokenizer state and per-character step logic.
// Depends on swt_pkg; the result is combinational from the item and the state.
module swt_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           end_of_string,
   input  logic [swt_pkg::BYTE_BITS-1:0]  char_code,
   input  logic [swt_pkg::BYTE_BITS-1:0]  sep_char,
   output swt_pkg::rsp_type               result
);

   swt_pkg::mode_type                    mode_ff, mode_in;
   logic [swt_pkg::POS_BITS-1:0]         position_ff, position_in;
   logic [swt_pkg::POS_BITS-1:0]         start_pos_ff, start_pos_in;
   logic [swt_pkg::POS_BITS-1:0]         end_pos_ff, end_pos_in;
   logic                                 start_known_ff, start_known_in;
   logic                                 word_open_ff, word_open_in;
   logic                                 nul_stop_ff, nul_stop_in;
   logic [swt_pkg::POS_BITS-1:0]         past;
   logic                                 close_now;

   assign past = (position_ff == swt_pkg::POS_MAX) ? position_ff
                                                   : position_ff + 1'b1;

   always_comb begin
      mode_in        = mode_ff;
      position_in    = position_ff;
      start_pos_in   = start_pos_ff;
      end_pos_in     = end_pos_ff;
      start_known_in = start_known_ff;
      word_open_in   = word_open_ff;
      nul_stop_in    = nul_stop_ff;
      close_now      = 1'b0;
      result         = '0;

      if (end_of_string) begin
         close_now            = word_open_ff;
         result.string_done   = 1'b1;
         result.missing_quote = mode_ff;
         mode_in              = swt_pkg::MODE_UNQ;
         position_in          = '0;
         start_pos_in         = '0;
         end_pos_in           = '0;
         start_known_in       = 1'b0;
         word_open_in         = 1'b0;
         nul_stop_in          = 1'b0;
      end else if (nul_stop_ff) begin
         // drop everything until end of string
      end else if (char_code == swt_pkg::CH_NUL) begin
         nul_stop_in = 1'b1;
      end else begin
         position_in = past;
         case (mode_ff)
            swt_pkg::MODE_BS, swt_pkg::MODE_DQBS: begin
               if (!start_known_ff) begin
                  start_pos_in   = position_ff;
                  start_known_in = 1'b1;
               end
               word_open_in = 1'b1;
               if (char_code != swt_pkg::CH_NL) begin
                  result.append_valid = 1'b1;
                  result.append_byte  = char_code;
               end
               end_pos_in = past;
               mode_in = (mode_ff == swt_pkg::MODE_BS) ? swt_pkg::MODE_UNQ
                                                       : swt_pkg::MODE_DQ;
            end
            swt_pkg::MODE_SQ: begin
               if (!start_known_ff) begin
                  start_pos_in   = position_ff;
                  start_known_in = 1'b1;
               end
               word_open_in = 1'b1;
               if (char_code == swt_pkg::CH_SQ) begin
                  mode_in = swt_pkg::MODE_UNQ;
               end else begin
                  result.append_valid = 1'b1;
                  result.append_byte  = char_code;
               end
               end_pos_in = past;
            end
            swt_pkg::MODE_DQ: begin
               if (!start_known_ff) begin
                  start_pos_in   = position_ff;
                  start_known_in = 1'b1;
               end
               word_open_in = 1'b1;
               if (char_code == swt_pkg::CH_DQ) begin
                  mode_in = swt_pkg::MODE_UNQ;
               end else if (char_code == swt_pkg::CH_BS) begin
                  mode_in = swt_pkg::MODE_DQBS;
               end else begin
                  result.append_valid = 1'b1;
                  result.append_byte  = char_code;
               end
               end_pos_in = past;
            end
            default: begin
               mode_in = swt_pkg::MODE_UNQ;
               if (swt_pkg::is_space(char_code)) begin
                  close_now = word_open_ff;
               end else if ((char_code == swt_pkg::CH_SQ) ||
                            (char_code == swt_pkg::CH_DQ) ||
                            (char_code == swt_pkg::CH_BS)) begin
                  if (!start_known_ff) begin
                     start_pos_in   = position_ff;
                     start_known_in = 1'b1;
                  end
                  word_open_in = 1'b1;
                  // opening quote moves the end only to its own offset
                  end_pos_in = position_ff;
                  if (char_code == swt_pkg::CH_SQ) begin
                     mode_in = swt_pkg::MODE_SQ;
                  end else if (char_code == swt_pkg::CH_DQ) begin
                     mode_in = swt_pkg::MODE_DQ;
                  end else begin
                     mode_in = swt_pkg::MODE_BS;
                  end
               end else if ((sep_char != swt_pkg::CH_NUL) &&
                            (char_code == sep_char)) begin
                  close_now         = word_open_ff;
                  start_known_in    = 1'b0;
                  result.line_break = 1'b1;
               end else begin
                  if (!start_known_ff) begin
                     start_pos_in   = position_ff;
                     start_known_in = 1'b1;
                  end
                  word_open_in        = 1'b1;
                  result.append_valid = 1'b1;
                  result.append_byte  = char_code;
                  end_pos_in          = past;
               end
            end
         endcase
      end

      if (close_now) begin
         result.word_done  = 1'b1;
         result.word_start = swt_pkg::OUT_POS_BITS'(start_pos_ff);
         result.word_end   = swt_pkg::OUT_POS_BITS'(end_pos_ff);
         word_open_in      = 1'b0;
         start_known_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= swt_pkg::MODE_UNQ;
         position_ff    <= '0;
         start_pos_ff   <= '0;
         end_pos_ff     <= '0;
         start_known_ff <= 1'b0;
         word_open_ff   <= 1'b0;
         nul_stop_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff        <= mode_in;
         position_ff    <= position_in;
         start_pos_ff   <= start_pos_in;
         end_pos_ff     <= end_pos_in;
         start_known_ff <= start_known_in;
         word_open_ff   <= word_open_in;
         nul_stop_ff    <= nul_stop_in;
      end
   end

endmodule

FILE: src/swt_out_buf.sv
// Result register with a skid stage behind it.
// Depends on swt_pkg for the result and status types.
module swt_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  swt_pkg::rsp_type       in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output swt_pkg::rsp_type       out_data,
   output swt_pkg::buf_status_type status
);

   logic             out_valid_ff, skid_valid_ff;
   swt_pkg::rsp_type out_data_ff, skid_data_ff;
   logic             pop, push;

   assign in_ready  = !skid_valid_ff;
   assign pop       = out_valid_ff && out_ready;
   assign push      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign status.out_valid  = out_valid_ff;
   assign status.skid_valid = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff && pop) begin
         out_data_ff   <= skid_data_ff;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_ff  <= in_data;
            out_valid_ff <= 1'b1;
         end else begin
            // hold the new item until the result register drains
            skid_data_ff  <= in_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

endmodule

FILE: src/shell_word_tokenizer_unit.sv
// Top level of the shell word tokenizer: stream ports, separator register.
// Depends on swt_pkg, swt_core and swt_out_buf.
//
// Takes one character (or an end-of-string mark) per clock while req_tready is high
// and gives exactly one result item for each. The step logic in swt_core is
// combinational; its result is registered in the result register, or in the one-entry
// skid stage while the result side stalls, which keeps the input flowing; req_tready
// drops only once both hold an item. No clearing pass after reset.
// Write the separator register only while the stream is idle.
module shell_word_tokenizer_unit (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [7:0] char_code
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   // req_tuser: [0] req_type (1 = end of string)
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rsp_tdata: [0] append_valid, [8:1] append_byte, [9] word_done,
   // [25:10] word_start, [41:26] word_end, [42] line_break,
   // [45:43] missing_quote, [47:46] zero
   output logic [swt_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // string_done
   output logic                               rsp_tlast,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [swt_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [swt_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [swt_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   logic [swt_pkg::BYTE_BITS-1:0] separator_ff;
   logic                          csr_write;
   logic                          csr_idx;
   logic                          accept;
   swt_pkg::rsp_type              step_result;
   swt_pkg::rsp_type              rsp;
   swt_pkg::buf_status_type       buf_status;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_idx == swt_pkg::CSR_IDX_SEPARATOR && csr_paddr[1:0] == 2'b00)
                     ? swt_pkg::CSR_DATA_BITS'(separator_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= '0;
      end else if (csr_write && csr_idx == swt_pkg::CSR_IDX_SEPARATOR) begin
         separator_ff <= csr_pwdata[swt_pkg::BYTE_BITS-1:0];
      end
   end

   assign accept = req_tvalid && req_tready;

   swt_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .end_of_string  (req_tuser),
      .char_code      (req_tdata),
      .sep_char       (separator_ff),
      .result         (step_result)
   );

   swt_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (step_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp),
      .status    (buf_status)
   );

   assign rsp_tdata = {2'b00, rsp.missing_quote, rsp.line_break, rsp.word_end,
                       rsp.word_start, rsp.word_done, rsp.append_byte,
                       rsp.append_valid};
   assign rsp_tlast = rsp.string_done;

`ifndef SYNTHESIS
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      buf_status.skid_valid |-> buf_status.out_valid)
      else $error("skid stage holds an item while the result register is empty");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (buf_status.out_valid && buf_status.skid_valid))
      else $error("input stalled with room in the output buffer");

   a_quote_code_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp.missing_quote == swt_pkg::MODE_UNQ))
      else $error("missing quote code given before end of string");

   a_no_append_on_break: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.line_break) |-> (!rsp.append_valid && !rsp.string_done))
      else $error("line break combined with append or end of string");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for shell_word_tokenizer_unit: streams characters and
// end-of-string marks, predicts each result item and compares it field by field.
// Depends on swt_pkg and the RTL of the block; reads no files.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS = 115;
   localparam int IDLE_PCT = 32;
   localparam int LONG_HOLD = 80;
   localparam logic [swt_pkg::CSR_ADDR_BITS-1:0] SEP_ADDR =
      {swt_pkg::CSR_IDX_SEPARATOR, 2'b00};
   localparam logic [swt_pkg::CSR_ADDR_BITS-1:0] SPARE_ADDR = 3'd4;
   localparam logic [swt_pkg::BYTE_BITS-1:0] CH_SEMI = 8'h3B;

   typedef struct packed {
      logic                          eos;
      logic [swt_pkg::BYTE_BITS-1:0] ch;
   } char_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;   // [7:0] char_code
   logic req_tuser = 1'b0;       // [0] req_type (1 = end of string)
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [0] append_valid, [8:1] append_byte, [9] word_done, [25:10] word_start,
   // [41:26] word_end, [42] line_break, [45:43] missing_quote, [47:46] zero
   logic [swt_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic rsp_tlast;              // string_done
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [swt_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [swt_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [swt_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   // tokenizer state as predicted
   logic [swt_pkg::BYTE_BITS-1:0] sep_byte;
   swt_pkg::mode_type tok_mode;
   logic [swt_pkg::POS_BITS-1:0] tok_pos, wstart_pos, wend_pos;
   logic wstart_known, in_word, nul_seen;

   char_item_t chars_to_send[$];
   swt_pkg::rsp_type predicted_results[$];
   int errors = 0;
   int cycles = 0;
   int queued = 0;
   int tx_idle_pct = IDLE_PCT;
   int rx_idle_pct = IDLE_PCT;
   int rx_hold = 0;
   bit req_taken = 1'b0;

   shell_word_tokenizer_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   function automatic void clear_string_state();
      tok_mode = swt_pkg::MODE_UNQ;
      tok_pos = '0;
      wstart_pos = '0;
      wstart_known = 1'b0;
      wend_pos = '0;
      in_word = 1'b0;
      nul_seen = 1'b0;
   endfunction

   function automatic void open_word();
      if (!wstart_known) begin
         wstart_pos = tok_pos;
         wstart_known = 1'b1;
      end
      in_word = 1'b1;
   endfunction

   function automatic void close_word(inout swt_pkg::rsp_type r);
      r.word_done = 1'b1;
      r.word_start = wstart_pos[swt_pkg::OUT_POS_BITS-1:0];
      r.word_end = wend_pos[swt_pkg::OUT_POS_BITS-1:0];
      in_word = 1'b0;
      wstart_known = 1'b0;
   endfunction

   function automatic swt_pkg::rsp_type tokenize_step(
      input logic eos, input logic [swt_pkg::BYTE_BITS-1:0] c);
      swt_pkg::rsp_type r;
      logic [swt_pkg::POS_BITS-1:0] nxt;
      r = '0;
      if (eos) begin
         if (in_word) close_word(r);
         r.string_done = 1'b1;
         r.missing_quote = tok_mode;
         clear_string_state();
         return r;
      end
      if (nul_seen) return r;
      if (c == swt_pkg::CH_NUL) begin
         nul_seen = 1'b1;
         return r;
      end
      nxt = (tok_pos == swt_pkg::POS_MAX) ? swt_pkg::POS_MAX : tok_pos + 1'b1;
      case (tok_mode)
         swt_pkg::MODE_BS, swt_pkg::MODE_DQBS: begin
            open_word();
            if (c != swt_pkg::CH_NL) begin
               r.append_valid = 1'b1;
               r.append_byte = c;
            end
            wend_pos = nxt;
            if (tok_mode == swt_pkg::MODE_BS) tok_mode = swt_pkg::MODE_UNQ;
            else tok_mode = swt_pkg::MODE_DQ;
         end
         swt_pkg::MODE_SQ: begin
            open_word();
            if (c == swt_pkg::CH_SQ) begin
               tok_mode = swt_pkg::MODE_UNQ;
            end else begin
               r.append_valid = 1'b1;
               r.append_byte = c;
            end
            wend_pos = nxt;
         end
         swt_pkg::MODE_DQ: begin
            open_word();
            if (c == swt_pkg::CH_DQ) begin
               tok_mode = swt_pkg::MODE_UNQ;
            end else if (c == swt_pkg::CH_BS) begin
               tok_mode = swt_pkg::MODE_DQBS;
            end else begin
               r.append_valid = 1'b1;
               r.append_byte = c;
            end
            wend_pos = nxt;
         end
         default: begin
            tok_mode = swt_pkg::MODE_UNQ;
            if (c == swt_pkg::CH_SP || (c >= swt_pkg::CH_TAB && c <= swt_pkg::CH_CR)) begin
               if (in_word) close_word(r);
            end else if (c == swt_pkg::CH_SQ || c == swt_pkg::CH_DQ ||
                         c == swt_pkg::CH_BS) begin
               // an opening quote ends the word only at its own offset
               open_word();
               wend_pos = tok_pos;
               if (c == swt_pkg::CH_SQ) tok_mode = swt_pkg::MODE_SQ;
               else if (c == swt_pkg::CH_DQ) tok_mode = swt_pkg::MODE_DQ;
               else tok_mode = swt_pkg::MODE_BS;
            end else if (sep_byte != '0 && c == sep_byte) begin
               if (in_word) close_word(r);
               wstart_known = 1'b0;
               r.line_break = 1'b1;
            end else begin
               open_word();
               r.append_valid = 1'b1;
               r.append_byte = c;
               wend_pos = nxt;
            end
         end
      endcase
      tok_pos = nxt;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // sample both channels at the rising edge
   always @(posedge clock) begin
      swt_pkg::rsp_type got;
      swt_pkg::rsp_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.append_valid = rsp_tdata[0];
            got.append_byte = rsp_tdata[8:1];
            got.word_done = rsp_tdata[9];
            got.word_start = rsp_tdata[25:10];
            got.word_end = rsp_tdata[41:26];
            got.line_break = rsp_tdata[42];
            got.missing_quote = rsp_tdata[45:43];
            got.string_done = rsp_tlast;
            if (predicted_results.size() == 0) begin
               $display("%0t unexpected item: expected none, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = predicted_results.pop_front();
               check_field("append_valid", want.append_valid, got.append_valid);
               check_field("append_byte", want.append_byte, got.append_byte);
               check_field("word_done", want.word_done, got.word_done);
               check_field("word_start", want.word_start, got.word_start);
               check_field("word_end", want.word_end, got.word_end);
               check_field("line_break", want.line_break, got.line_break);
               check_field("string_done", want.string_done, got.string_done);
               check_field("missing_quote", want.missing_quote, got.missing_quote);
               check_field("tdata pad", '0, rsp_tdata[swt_pkg::RSP_TDATA_BITS-1:46]);
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            predicted_results.push_back(tokenize_step(req_tuser, req_tdata));
         end
      end
   end

   always @(negedge clock) begin
      char_item_t nxt_item;
      if (!req_tvalid || req_taken) begin
         if (chars_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            nxt_item = chars_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= nxt_item.ch;
            req_tuser <= nxt_item.eos;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic push_char(input logic [swt_pkg::BYTE_BITS-1:0] c);
      chars_to_send.push_back('{eos: 1'b0, ch: c});
      queued++;
   endtask

   task automatic push_eos();
      chars_to_send.push_back('{eos: 1'b1, ch: swt_pkg::BYTE_BITS'($urandom)});
      queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   function automatic logic [swt_pkg::BYTE_BITS-1:0] pick_plain();
      int r;
      r = $urandom_range(99);
      if (r < 70) return swt_pkg::BYTE_BITS'(8'h61 + $urandom_range(25));
      if (r < 85) return swt_pkg::BYTE_BITS'(8'h30 + $urandom_range(9));
      return swt_pkg::BYTE_BITS'($urandom_range(8'h21, 8'h7E));
   endfunction

   // content inside quotes; never NUL and never the closing byte
   function automatic logic [swt_pkg::BYTE_BITS-1:0] pick_quoted(
      input logic [swt_pkg::BYTE_BITS-1:0] closing);
      int r;
      logic [swt_pkg::BYTE_BITS-1:0] c;
      r = $urandom_range(99);
      if (r < 50) c = pick_plain();
      else if (r < 65) c = swt_pkg::CH_SP;
      else if (r < 75) c = (sep_byte == '0) ? CH_SEMI : sep_byte;
      else c = swt_pkg::BYTE_BITS'($urandom_range(1, 255));
      if (c == closing || c == swt_pkg::CH_NUL) c = 8'h78;
      return c;
   endfunction

   task automatic gen_string();
      int ntok;
      int kind;
      int n;
      ntok = $urandom_range(1, 8);
      repeat (ntok) begin
         kind = $urandom_range(99);
         n = $urandom_range(0, 5);
         if (kind < 30) begin
            push_char(pick_plain());
            repeat (n) push_char(pick_plain());
         end else if (kind < 45) begin
            repeat (n % 3 + 1) push_char($urandom_range(3) == 0 ?
               swt_pkg::BYTE_BITS'(swt_pkg::CH_TAB + $urandom_range(4)) : swt_pkg::CH_SP);
         end else if (kind < 55) begin
            push_char(swt_pkg::CH_SQ);
            repeat (n) push_char(pick_quoted(swt_pkg::CH_SQ));
            if ($urandom_range(9) != 0) push_char(swt_pkg::CH_SQ);
         end else if (kind < 67) begin
            push_char(swt_pkg::CH_DQ);
            repeat (n) begin
               if ($urandom_range(3) == 0) begin
                  push_char(swt_pkg::CH_BS);
                  push_char($urandom_range(2) == 0 ? swt_pkg::CH_DQ
                                                   : pick_quoted(swt_pkg::CH_NUL));
               end else begin
                  push_char(pick_quoted(swt_pkg::CH_DQ));
               end
            end
            if ($urandom_range(9) != 0) push_char(swt_pkg::CH_DQ);
         end else if (kind < 75) begin
            push_char(swt_pkg::CH_BS);
            if ($urandom_range(9) != 0)
               push_char($urandom_range(2) == 0 ? swt_pkg::CH_NL
                                                : pick_quoted(swt_pkg::CH_NUL));
         end else if (kind < 86) begin
            push_char((sep_byte == '0) ? CH_SEMI : sep_byte);
         end else if (kind < 97) begin
            push_char(swt_pkg::BYTE_BITS'($urandom_range(1, 255)));
         end else begin
            // stop parsing, the rest of the string is dropped
            push_char(swt_pkg::CH_NUL);
            repeat (n) push_char(swt_pkg::BYTE_BITS'($urandom_range(255)));
         end
      end
      push_eos();
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (chars_to_send.size() != 0 || req_tvalid || predicted_results.size() != 0);
   endtask

   task automatic csr_write(input logic [swt_pkg::CSR_ADDR_BITS-1:0] addr,
                            input logic [swt_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = data;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic read_separator();
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b0;
      csr_paddr = SEP_ADDR;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      check_field("separator readback", sep_byte, csr_prdata[swt_pkg::BYTE_BITS-1:0]);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_separator(input logic [swt_pkg::BYTE_BITS-1:0] sep,
                                input int idle_pct);
      wait_idle();
      // upper bits are junk; the register keeps one byte
      csr_write(SEP_ADDR, {24'($urandom), sep});
      sep_byte = sep;
      read_separator();
      tx_idle_pct = idle_pct;
      rx_idle_pct = idle_pct;
   endtask

   task automatic random_items(input int n_items, input int hold);
      int goal;
      goal = queued + n_items;
      while (queued < goal) gen_string();
      if (hold > 0) begin
         @(posedge clock);
         rx_hold = hold;
      end
   endtask

   initial begin
      sep_byte = '0;
      clear_string_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      read_separator();

      // no separator: quoting, escapes, byte extremes, unclosed quote, NUL
      push_text("a 'b'\t\"\\\"x\"\\\n");
      push_char(8'hFF);
      push_char(swt_pkg::CH_CR);
      push_eos();
      push_text("\"\\");
      push_eos();
      push_text("q");
      push_char(swt_pkg::CH_NUL);
      push_eos();

      // separator after a word, with no word open, and inside quotes
      set_separator(CH_SEMI, IDLE_PCT);
      push_text("a;;b';'");
      push_eos();
      random_items(PHASE_ITEMS, LONG_HOLD);

      // write to an unmapped register must leave the separator alone
      wait_idle();
      csr_write(SPARE_ADDR, $urandom);
      read_separator();

      set_separator(8'hFF, IDLE_PCT);
      random_items(PHASE_ITEMS, 0);
      set_separator(8'h01, 0);
      random_items(PHASE_ITEMS, 0);
      set_separator(swt_pkg::CH_SP, IDLE_PCT);
      random_items(PHASE_ITEMS, 0);
      set_separator(swt_pkg::CH_SQ, IDLE_PCT);
      random_items(PHASE_ITEMS, 0);
      set_separator(swt_pkg::CH_DQ, IDLE_PCT);
      random_items(PHASE_ITEMS, 0);
      set_separator(swt_pkg::CH_BS, IDLE_PCT);
      random_items(PHASE_ITEMS, LONG_HOLD);
      set_separator(swt_pkg::CH_NL, IDLE_PCT);
      random_items(PHASE_ITEMS, 0);
      set_separator(swt_pkg::BYTE_BITS'($urandom_range(1, 255)), IDLE_PCT);
      random_items(PHASE_ITEMS, 0);
      set_separator(8'h00, IDLE_PCT);
      random_items(PHASE_ITEMS, 0);

      // mixed words around a separator, ending inside an open single quote
      set_separator(CH_SEMI, IDLE_PCT);
      push_text("ab 'cd' \"e\\f\" \\g h;i '");
      push_eos();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
